[src/dsf_pkg.sv]
package dsf_pkg;

  // Screen geometry and burst size
  localparam int MAX_ROWS = 16;
  localparam int COLUMNS  = 30;
  localparam int BURST    = 64;
  localparam int CELLS    = MAX_ROWS * COLUMNS;

  // Field widths
  localparam int OP_W   = 2;
  localparam int POS_W  = 9;
  localparam int CHAR_W = 8;
  localparam int ROWS_W = 5;
  localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(13);

  // Burst bookkeeping
  localparam int CNT_W  = $clog2(BURST + 1);
  localparam int RIDX_W = (BURST > 1) ? $clog2(BURST) : 1;
  localparam int RES_W  = POS_W + CHAR_W;

  // Request queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_REFRESH = 2'd1,
    OP_MARK    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    op_t               kind;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] character;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

endpackage

[src/dsf_ram.sv]
module dsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/dsf_front.sv]
module dsf_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dsf_pkg::OP_W-1:0]    operation,
  input  logic [dsf_pkg::POS_W-1:0]   position,
  input  logic [dsf_pkg::CHAR_W-1:0]  character,
  output logic                        cmd_valid,
  output dsf_pkg::cmd_t               cmd,
  input  dsf_pkg::back_ctl_t          ctl
);

  dsf_pkg::cmd_t                 q [dsf_pkg::QDEPTH];
  logic [dsf_pkg::QPTR_W-1:0]    wr_ptr;
  logic [dsf_pkg::QPTR_W-1:0]    rd_ptr;
  logic [dsf_pkg::QCNT_W-1:0]    count;
  logic                          keep;
  logic                          push;
  logic                          pop;
  dsf_pkg::cmd_t                 new_cmd;

  // Drop unused codes and writes that fall off the screen
  always_comb begin
    keep = (operation == dsf_pkg::OP_REFRESH) || (operation == dsf_pkg::OP_MARK) ||
           ((operation == dsf_pkg::OP_WRITE) &&
            (position < dsf_pkg::POS_W'(dsf_pkg::CELLS)));
    new_cmd.kind      = dsf_pkg::op_t'(operation);
    new_cmd.position  = position;
    new_cmd.character = character;
  end

  assign in_stall  = (count == dsf_pkg::QCNT_W'(dsf_pkg::QDEPTH)) || ctl.clearing;
  assign push      = in_valid && !in_stall && keep;
  assign pop       = ctl.pop;
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= new_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= dsf_pkg::QCNT_W'(dsf_pkg::QDEPTH))
    else $error("request queue overfilled");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty request queue");

endmodule

[src/dsf_back.sv]
module dsf_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [dsf_pkg::ROWS_W-1:0]    cfg_wr_data,
  input  logic                          cmd_valid,
  input  dsf_pkg::cmd_t                 cmd,
  output dsf_pkg::back_ctl_t            ctl,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dsf_pkg::POS_W-1:0]     display_address,
  output logic [dsf_pkg::CHAR_W-1:0]    character_res,
  output logic                          last_in_burst,
  output logic                          scan_complete
);

  dsf_pkg::state_t state, state_next;

  logic [dsf_pkg::ROWS_W-1:0]  rows_in_use;
  logic [dsf_pkg::POS_W-1:0]   sweep_idx;
  logic                        sweep_last;
  logic                        frame_dirty;
  logic                        scan_active;
  logic [dsf_pkg::POS_W-1:0]   scan_pos;
  logic [dsf_pkg::POS_W-1:0]   scan_limit;
  logic [dsf_pkg::POS_W-1:0]   limit_calc;
  logic [dsf_pkg::ROWS_W-1:0]  rows_clamped;
  logic                        eval_valid;
  logic [dsf_pkg::POS_W-1:0]   eval_addr;
  logic [dsf_pkg::POS_W-1:0]   eval_next_pos;
  logic [dsf_pkg::CNT_W-1:0]   count;
  logic [dsf_pkg::RIDX_W-1:0]  drain_idx;
  logic                        drain_last;
  logic                        rd_fresh;
  logic                        burst_done;
  logic                        scan_done;
  logic                        start_scan;

  // Strobes
  logic                        issue;
  logic                        stop_now;
  logic                        scan_end;
  logic                        load;

  // Screen memories
  logic                        char_we;
  logic                        dirty_we;
  logic [dsf_pkg::POS_W-1:0]   wr_addr;
  logic [dsf_pkg::CHAR_W-1:0]  char_wdata;
  logic                        dirty_wdata;
  logic [dsf_pkg::CHAR_W-1:0]  char_rdata;
  logic                        dirty_rdata;

  // Result buffer
  logic                        res_we;
  logic [dsf_pkg::RIDX_W-1:0]  res_raddr;
  logic [dsf_pkg::RES_W-1:0]   res_rdata;

  dsf_ram #(.WIDTH(dsf_pkg::CHAR_W), .DEPTH(dsf_pkg::CELLS)) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (wr_addr),
    .wdata (char_wdata),
    .raddr (scan_pos),
    .rdata (char_rdata)
  );

  dsf_ram #(.WIDTH(1), .DEPTH(dsf_pkg::CELLS)) u_dirty_ram (
    .clk   (clk),
    .we    (dirty_we),
    .waddr (wr_addr),
    .wdata (dirty_wdata),
    .raddr (scan_pos),
    .rdata (dirty_rdata)
  );

  dsf_ram #(.WIDTH(dsf_pkg::RES_W), .DEPTH(dsf_pkg::BURST)) u_res_ram (
    .clk   (clk),
    .we    (res_we),
    .waddr (count[dsf_pkg::RIDX_W-1:0]),
    .wdata ({eval_addr, char_rdata}),
    .raddr (res_raddr),
    .rdata (res_rdata)
  );

  always_comb begin
    rows_clamped = (rows_in_use > dsf_pkg::ROWS_W'(dsf_pkg::MAX_ROWS)) ?
                   dsf_pkg::ROWS_W'(dsf_pkg::MAX_ROWS) : rows_in_use;
    limit_calc    = dsf_pkg::POS_W'(int'(rows_clamped) * dsf_pkg::COLUMNS);
    sweep_last    = (sweep_idx == dsf_pkg::POS_W'(dsf_pkg::CELLS - 1));
    eval_next_pos = eval_addr + 1'b1;
    drain_last    = ((dsf_pkg::CNT_W'(drain_idx) + dsf_pkg::CNT_W'(1)) == count);
    start_scan    = scan_active || frame_dirty;
    scan_done     = !stop_now || (eval_next_pos >= scan_limit);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dsf_pkg::ST_CLEAR: begin
        if (sweep_last) begin
          state_next = dsf_pkg::ST_IDLE;
        end
      end
      dsf_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            dsf_pkg::OP_MARK:    state_next = dsf_pkg::ST_MARK;
            dsf_pkg::OP_REFRESH: begin
              if (start_scan) begin
                state_next = dsf_pkg::ST_SCAN;
              end
            end
            default:             state_next = dsf_pkg::ST_IDLE;
          endcase
        end
      end
      dsf_pkg::ST_MARK: begin
        if (sweep_last) begin
          state_next = dsf_pkg::ST_IDLE;
        end
      end
      dsf_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = (stop_now || (count != '0)) ? dsf_pkg::ST_DRAIN : dsf_pkg::ST_IDLE;
        end
      end
      dsf_pkg::ST_DRAIN: begin
        if (load && drain_last) begin
          state_next = dsf_pkg::ST_IDLE;
        end
      end
      default: state_next = dsf_pkg::ST_CLEAR;
    endcase
  end

  // Control strobes and memory ports
  always_comb begin
    ctl.pop      = 1'b0;
    ctl.clearing = 1'b0;
    char_we      = 1'b0;
    dirty_we     = 1'b0;
    wr_addr      = sweep_idx;
    char_wdata   = '0;
    dirty_wdata  = 1'b0;
    res_we       = 1'b0;
    issue        = 1'b0;
    stop_now     = 1'b0;
    scan_end     = 1'b0;
    load         = 1'b0;
    unique case (state)
      dsf_pkg::ST_CLEAR: begin
        ctl.clearing = 1'b1;
        char_we      = 1'b1;
        dirty_we     = 1'b1;
      end
      dsf_pkg::ST_IDLE: begin
        ctl.pop = cmd_valid;
        if (cmd_valid && (cmd.kind == dsf_pkg::OP_WRITE)) begin
          char_we     = 1'b1;
          dirty_we    = 1'b1;
          dirty_wdata = 1'b1;
          wr_addr     = cmd.position;
          char_wdata  = cmd.character;
        end
      end
      dsf_pkg::ST_MARK: begin
        dirty_we    = 1'b1;
        dirty_wdata = 1'b1;
      end
      dsf_pkg::ST_SCAN: begin
        stop_now = eval_valid && dirty_rdata &&
                   (count == dsf_pkg::CNT_W'(dsf_pkg::BURST - 1));
        issue    = !stop_now && (scan_pos < scan_limit);
        scan_end = stop_now || (!issue && !eval_valid);
        if (eval_valid && dirty_rdata) begin
          res_we   = 1'b1;
          dirty_we = 1'b1;
          wr_addr  = eval_addr;
        end
      end
      dsf_pkg::ST_DRAIN: begin
        load = rd_fresh && (!out_valid || !out_stall);
      end
      default: begin
        ctl.clearing = 1'b1;
      end
    endcase
    res_raddr = load ? drain_idx + 1'b1 : drain_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dsf_pkg::ST_CLEAR;
      rows_in_use <= dsf_pkg::ROWS_RESET;
      sweep_idx   <= '0;
      frame_dirty <= 1'b0;
      scan_active <= 1'b0;
      scan_pos    <= '0;
      eval_valid  <= 1'b0;
      count       <= '0;
      drain_idx   <= '0;
      rd_fresh    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      rd_fresh <= (state == dsf_pkg::ST_DRAIN);
      if (cfg_wr_en) begin
        rows_in_use <= cfg_wr_data;
      end
      if ((state == dsf_pkg::ST_CLEAR) || (state == dsf_pkg::ST_MARK)) begin
        sweep_idx <= sweep_last ? '0 : sweep_idx + 1'b1;
      end
      if (state == dsf_pkg::ST_IDLE && cmd_valid) begin
        unique case (cmd.kind)
          dsf_pkg::OP_WRITE: frame_dirty <= 1'b1;
          dsf_pkg::OP_MARK:  frame_dirty <= 1'b1;
          dsf_pkg::OP_REFRESH: begin
            if (start_scan) begin
              count <= '0;
              if (!scan_active) begin
                frame_dirty <= 1'b0;
                scan_active <= 1'b1;
                scan_pos    <= '0;
              end
            end
          end
          default: frame_dirty <= frame_dirty;
        endcase
      end
      if (state == dsf_pkg::ST_SCAN) begin
        eval_valid <= issue;
        if (issue) begin
          scan_pos <= scan_pos + 1'b1;
        end
        if (res_we) begin
          count <= count + 1'b1;
        end
        if (scan_end) begin
          if (scan_done) begin
            scan_active <= 1'b0;
            scan_pos    <= '0;
          end else begin
            scan_pos <= eval_next_pos;
          end
        end
      end
      if (load) begin
        drain_idx <= drain_last ? '0 : drain_idx + 1'b1;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == dsf_pkg::ST_IDLE && cmd_valid && cmd.kind == dsf_pkg::OP_REFRESH) begin
      scan_limit <= limit_calc;
    end
    eval_addr <= scan_pos;
    if (scan_end) begin
      burst_done <= scan_done;
    end
    if (load) begin
      display_address <= res_rdata[dsf_pkg::RES_W-1:dsf_pkg::CHAR_W];
      character_res   <= res_rdata[dsf_pkg::CHAR_W-1:0];
      last_in_burst   <= drain_last;
      scan_complete   <= burst_done;
    end
  end

  a_idle_scan_home: assert property (@(posedge clk) disable iff (rst)
    !scan_active |-> scan_pos == '0)
    else $error("scan position left off home while no scan is under way");

  a_eval_in_scan: assert property (@(posedge clk) disable iff (rst)
    eval_valid |-> state == dsf_pkg::ST_SCAN)
    else $error("cell lookup in flight outside a scan");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == dsf_pkg::ST_DRAIN) |-> (count != '0) &&
      (count <= dsf_pkg::CNT_W'(dsf_pkg::BURST)))
    else $error("drain entered with an empty or overfull result buffer");

endmodule

[src/dirty_shadow_screen_flush_top.sv]
// A request enters the queue at its accept edge; the engine takes it from the queue head once idle.
// A character write is done in the idle state; mark-all marks every cell dirty, one cell a cycle.
// A refresh scans the cells of the rows in use for dirty cells, then drains the buffered updates
// to the output register, holding while out_stall is high.
// Reset (rst, synchronous): rows_in_use returns to 13 and a clearing pass over every cell zeroes
// the character and dirty memories; in_stall stays high for that pass.
module dirty_shadow_screen_flush_top (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration: rows_in_use
  input  logic                        cfg_wr_en,
  input  logic [dsf_pkg::ROWS_W-1:0]  cfg_wr_data,
  // Request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dsf_pkg::OP_W-1:0]    operation,
  input  logic [dsf_pkg::POS_W-1:0]   position,
  input  logic [dsf_pkg::CHAR_W-1:0]  character,
  // Update channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dsf_pkg::POS_W-1:0]   display_address,
  output logic [dsf_pkg::CHAR_W-1:0]  character_res,
  output logic                        last_in_burst,
  output logic                        scan_complete
);

  // Front to back: queued requests; back to front: pop and clearing status.
  logic                cmd_valid;
  dsf_pkg::cmd_t       cmd;
  dsf_pkg::back_ctl_t  ctl;

  // Front: accept requests, drop unused codes and off-screen writes, queue the rest.
  dsf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .position  (position),
    .character (character),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .ctl       (ctl)
  );

  // Back: hold the shadow screen, run writes, mark-all sweeps and refresh scans,
  // buffer each burst and drain it through the output register.
  dsf_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .ctl             (ctl),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .display_address (display_address),
    .character_res   (character_res),
    .last_in_burst   (last_in_burst),
    .scan_complete   (scan_complete)
  );

endmodule
